[rtl/ppp_pkg.sv]
// shared types, constants and arithmetic helpers of the perspective point projector
package ppp_pkg;

    localparam int TRIG_FRAC  = 16;
    localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);
    localparam int QUOT_BITS  = 32;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic signed [17:0] RST_COS_YAW   = 18'sd65536;
    localparam logic signed [17:0] RST_SIN_YAW   = 18'sd0;
    localparam logic signed [17:0] RST_COS_PITCH = 18'sd65536;
    localparam logic signed [17:0] RST_SIN_PITCH = 18'sd0;
    localparam logic signed [31:0] RST_CAM_X     = 32'sd0;
    localparam logic signed [31:0] RST_CAM_Y     = 32'sd0;
    localparam logic signed [31:0] RST_CAM_Z     = 32'sd131072;
    localparam logic [30:0]        RST_SCREEN_D  = 31'd65536;

    typedef enum logic [2:0] {
        REG_COS_YAW   = 3'd0,
        REG_SIN_YAW   = 3'd1,
        REG_COS_PITCH = 3'd2,
        REG_SIN_PITCH = 3'd3,
        REG_CAM_X     = 3'd4,
        REG_CAM_Y     = 3'd5,
        REG_CAM_Z     = 3'd6,
        REG_SCREEN_D  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic zero;
        logic nzero;
        logic neg;
        logic numneg;
        logic ovf;
    } t_div_tag;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic signed [31:0] quot;
    } t_div_res;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 40'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] rot_round(input logic signed [51:0] s);
        logic signed [51:0] t;
        t = s + 52'(ROUND_HALF);
        return sat32(40'(t >>> TRIG_FRAC));
    endfunction

endpackage

[rtl/ppp_div.sv]
// pipelined signed 64 by 32 divider, one quotient bit per stage, saturating
module ppp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [63:0]  i_num,
    input  logic signed [31:0]  i_den,
    output ppp_pkg::t_div_res   o_res
);

    localparam int NQ = ppp_pkg::QUOT_BITS;

    logic              r_a_v;
    logic              r_a_nneg;
    logic              r_a_dneg;
    logic [62:0]       r_a_n;
    logic [31:0]       r_a_d;

    ppp_pkg::t_div_tag r_tag [0:NQ];
    logic [31:0]       r_rem [0:NQ];
    logic [31:0]       r_low [0:NQ];
    logic [31:0]       r_d   [0:NQ];

    ppp_pkg::t_div_res r_res;
    ppp_pkg::t_div_res n_res;

    // magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            r_a_nneg <= i_num[63];
            r_a_dneg <= i_den[31];
            r_a_n    <= i_num[63] ? 63'(-i_num) : 63'(i_num);
            r_a_d    <= i_den[31] ? 32'(-i_den) : 32'(i_den);
        end
    end

    // special cases and first partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0].valid  <= r_a_v;
            r_tag[0].zero   <= (r_a_d == 32'd0);
            r_tag[0].nzero  <= (r_a_n == 63'd0);
            r_tag[0].neg    <= r_a_nneg ^ r_a_dneg;
            r_tag[0].numneg <= r_a_nneg;
            r_tag[0].ovf    <= ({1'b0, r_a_n} >= {r_a_d, 32'd0});
        end
        if (i_en) begin
            r_rem[0] <= {1'b0, r_a_n[62:32]};
            r_low[0] <= r_a_n[31:0];
            r_d[0]   <= r_a_d;
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_step
        logic [32:0] t;
        logic [32:0] diff;
        logic        ge;

        assign t    = {r_rem[k], r_low[k][31]};
        assign diff = t - {1'b0, r_d[k]};
        assign ge   = (t >= {1'b0, r_d[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else if (i_en) begin
                r_tag[k+1] <= r_tag[k];
            end
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[31:0] : t[31:0];
                r_low[k+1] <= {r_low[k][30:0], ge};
                r_d[k+1]   <= r_d[k];
            end
        end
    end

    // sign and saturation
    always_comb begin
        n_res.valid = r_tag[NQ].valid;
        n_res.zero  = r_tag[NQ].zero;
        priority if (r_tag[NQ].zero) begin
            if (r_tag[NQ].nzero) begin
                n_res.quot = 32'sd0;
            end else if (r_tag[NQ].numneg) begin
                n_res.quot = ppp_pkg::S32_MIN;
            end else begin
                n_res.quot = ppp_pkg::S32_MAX;
            end
        end else if (r_tag[NQ].ovf) begin
            n_res.quot = r_tag[NQ].neg ? ppp_pkg::S32_MIN : ppp_pkg::S32_MAX;
        end else if (r_tag[NQ].neg) begin
            n_res.quot = (r_low[NQ] > 32'h8000_0000) ? ppp_pkg::S32_MIN
                                                      : $signed(32'(-r_low[NQ]));
        end else begin
            n_res.quot = r_low[NQ][31] ? ppp_pkg::S32_MAX : $signed(r_low[NQ]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[rtl/perspective_point_projector.sv]
// perspective point projector top level: register port, transform pipeline, output skid
//
// One point word is accepted per clock cycle while o_in_ready is high, and one screen
// word leaves per cycle while i_out_ready is high. A point passes through six stages
// of rotation, offset and scale multiplies, two setup stages and one stage per
// quotient bit of the 32-bit pipelined divider, a saturation stage and the output
// register. A skid register behind the output holds one word while a result waits
// to be taken; input acceptance stops while the skid is full. The user must write
// registers through the APB port only while no point is in flight; the block itself does not enforce this.
module perspective_point_projector (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    output logic               o_zero_depth
);

    logic signed [17:0] r_cos_yaw;
    logic signed [17:0] r_sin_yaw;
    logic signed [17:0] r_cos_pitch;
    logic signed [17:0] r_sin_pitch;
    logic signed [31:0] r_cam_x;
    logic signed [31:0] r_cam_y;
    logic signed [31:0] r_cam_z;
    logic [30:0]        r_screen_d;

    ppp_pkg::t_reg_idx  wr_idx;
    logic               wr_en;
    logic               en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = ppp_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_yaw   <= ppp_pkg::RST_COS_YAW;
            r_sin_yaw   <= ppp_pkg::RST_SIN_YAW;
            r_cos_pitch <= ppp_pkg::RST_COS_PITCH;
            r_sin_pitch <= ppp_pkg::RST_SIN_PITCH;
            r_cam_x     <= ppp_pkg::RST_CAM_X;
            r_cam_y     <= ppp_pkg::RST_CAM_Y;
            r_cam_z     <= ppp_pkg::RST_CAM_Z;
            r_screen_d  <= ppp_pkg::RST_SCREEN_D;
        end else if (wr_en) begin
            unique case (wr_idx)
                ppp_pkg::REG_COS_YAW:   r_cos_yaw   <= pwdata[17:0];
                ppp_pkg::REG_SIN_YAW:   r_sin_yaw   <= pwdata[17:0];
                ppp_pkg::REG_COS_PITCH: r_cos_pitch <= pwdata[17:0];
                ppp_pkg::REG_SIN_PITCH: r_sin_pitch <= pwdata[17:0];
                ppp_pkg::REG_CAM_X:     r_cam_x     <= pwdata;
                ppp_pkg::REG_CAM_Y:     r_cam_y     <= pwdata;
                ppp_pkg::REG_CAM_Z:     r_cam_z     <= pwdata;
                ppp_pkg::REG_SCREEN_D:  r_screen_d  <= pwdata[30:0];
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            ppp_pkg::REG_COS_YAW:   prdata = 32'(r_cos_yaw);
            ppp_pkg::REG_SIN_YAW:   prdata = 32'(r_sin_yaw);
            ppp_pkg::REG_COS_PITCH: prdata = 32'(r_cos_pitch);
            ppp_pkg::REG_SIN_PITCH: prdata = 32'(r_sin_pitch);
            ppp_pkg::REG_CAM_X:     prdata = r_cam_x;
            ppp_pkg::REG_CAM_Y:     prdata = r_cam_y;
            ppp_pkg::REG_CAM_Z:     prdata = r_cam_z;
            ppp_pkg::REG_SCREEN_D:  prdata = {1'b0, r_screen_d};
        endcase
    end

    // pipeline registers
    logic               r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;
    logic signed [49:0] r_a_pcx, r_a_psy, r_a_pcy, r_a_psx;
    logic signed [31:0] r_a_z;
    logic signed [31:0] r_b_x1, r_b_y1, r_b_z;
    logic signed [49:0] r_c_pcx, r_c_psz, r_c_pcz, r_c_psx;
    logic signed [31:0] r_c_y1;
    logic signed [31:0] r_d_x2, r_d_y1, r_d_z2;
    logic signed [31:0] r_e_x3, r_e_y3, r_e_z3;
    logic signed [63:0] r_f_nx, r_f_ny;
    logic signed [31:0] r_f_z3;
    logic signed [31:0] sd_s;

    logic               r_s_valid;
    logic               r_o_valid;
    logic signed [31:0] r_o_x, r_o_y, r_s_x, r_s_y;
    logic               r_o_zero, r_s_zero;

    ppp_pkg::t_div_res  div_x;
    ppp_pkg::t_div_res  div_y;
    logic               new_word;
    logic               out_take;

    assign en         = !r_s_valid;
    assign o_in_ready = en;
    assign sd_s       = $signed({1'b0, r_screen_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // pitch products
            r_a_pcx <= r_cos_pitch * i_point_x;
            r_a_psy <= r_sin_pitch * i_point_y;
            r_a_pcy <= r_cos_pitch * i_point_y;
            r_a_psx <= r_sin_pitch * i_point_x;
            r_a_z   <= i_point_z;
            // pitch rotation
            r_b_x1  <= ppp_pkg::rot_round(52'(r_a_pcx) + 52'(r_a_psy));
            r_b_y1  <= ppp_pkg::rot_round(52'(r_a_pcy) - 52'(r_a_psx));
            r_b_z   <= r_a_z;
            // yaw products
            r_c_pcx <= r_cos_yaw * r_b_x1;
            r_c_psz <= r_sin_yaw * r_b_z;
            r_c_pcz <= r_cos_yaw * r_b_z;
            r_c_psx <= r_sin_yaw * r_b_x1;
            r_c_y1  <= r_b_y1;
            // yaw rotation
            r_d_x2  <= ppp_pkg::rot_round(52'(r_c_pcx) + 52'(r_c_psz));
            r_d_z2  <= ppp_pkg::rot_round(52'(r_c_pcz) - 52'(r_c_psx));
            r_d_y1  <= r_c_y1;
            // camera offset
            r_e_x3  <= ppp_pkg::sat32(40'(r_d_x2) + 40'(r_cam_x));
            r_e_y3  <= ppp_pkg::sat32(40'(r_d_y1) + 40'(r_cam_y));
            r_e_z3  <= ppp_pkg::sat32(40'(r_d_z2) + 40'(r_cam_z));
            // scale numerators
            r_f_nx  <= sd_s * r_e_x3;
            r_f_ny  <= sd_s * r_e_y3;
            r_f_z3  <= r_e_z3;
        end
    end

    ppp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   (r_f_nx),
        .i_den   (r_f_z3),
        .o_res   (div_x)
    );

    ppp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   (r_f_ny),
        .i_den   (r_f_z3),
        .o_res   (div_y)
    );

    // output register with skid
    assign new_word = en && div_x.valid;
    assign out_take = r_o_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (!r_o_valid || out_take) begin
            if (r_s_valid) begin
                r_o_valid <= 1'b1;
                r_s_valid <= 1'b0;
            end else begin
                r_o_valid <= new_word;
            end
        end else if (new_word) begin
            r_s_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || out_take) begin
            if (r_s_valid) begin
                r_o_x    <= r_s_x;
                r_o_y    <= r_s_y;
                r_o_zero <= r_s_zero;
            end else begin
                r_o_x    <= div_x.quot;
                r_o_y    <= div_y.quot;
                r_o_zero <= div_x.zero;
            end
        end else if (new_word) begin
            r_s_x    <= div_x.quot;
            r_s_y    <= div_y.quot;
            r_s_zero <= div_x.zero;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_screen_x   = r_o_x;
    assign o_screen_y   = r_o_y;
    assign o_zero_depth = r_o_zero;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_o_valid)
        else $error("skid holds a word while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s_valid) |-> $past(r_o_valid && !i_out_ready))
        else $error("skid filled without an output stall");

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_depth) |->
        (o_screen_x == ppp_pkg::S32_MAX || o_screen_x == ppp_pkg::S32_MIN ||
         o_screen_x == 32'sd0))
        else $error("zero depth word not saturated");

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_x.valid == div_y.valid)
        else $error("divider lanes out of step");
`endif

endmodule
